// ----- hdl/sjis_pkg.sv -----
// shared types, constants and helper functions for the shift-jis to ucs-2 converter
// used by the front, back and top modules of the block; no dependencies
package sjis_pkg;

    // defaults for the top-level parameters
    localparam int MAX_RANGES_DEF  = 16;
    localparam int TABLE_DEPTH_DEF = 16384;
    localparam int QUEUE_DEPTH     = 4;

    // action codes carried in the input tuser
    localparam logic [1:0] ACT_CONVERT = 2'd0;
    localparam logic [1:0] ACT_RANGE   = 2'd1;
    localparam logic [1:0] ACT_TABLE   = 2'd2;

    // configuration register indexes (paddr[2])
    localparam logic REG_RANGE_COUNT = 1'b0;
    localparam logic REG_ERROR_CODE  = 1'b1;

    // input tdata layout, lowest bit first
    localparam int IN_DATA_W   = 96;
    localparam int IN_USER_W   = 2;
    localparam int LEAD_LSB    = 0;
    localparam int NEXT_LSB    = 8;
    localparam int IDX_LSB     = 16;
    localparam int FIRST_LSB   = 30;
    localparam int LAST_LSB    = 46;
    localparam int BASE_LSB    = 62;
    localparam int WORD_LSB    = 78;

    // output layout
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;

    // rebuilt two-byte code is signed and needs 19 bits
    localparam int CODE_W = 19;
    localparam int ADDR_W = 16;

    localparam logic signed [CODE_W-1:0] REBUILD_BASE   = 19'sh0E100;
    localparam logic signed [CODE_W-1:0] HIGH_LEAD_ADJ  = 19'sh08000;
    localparam logic signed [CODE_W-1:0] TRAIL_LOW_ADJ  = 19'sh0001F;
    localparam logic signed [CODE_W-1:0] TRAIL_HIGH_ADJ = 19'sh00082;
    localparam logic signed [CODE_W-1:0] TRAIL_MID_ADJ  = 19'sh00020;
    localparam logic [7:0] HIGH_LEAD_MIN = 8'hE0;
    localparam logic [7:0] TRAIL_LOW_MAX = 8'h7E;
    localparam logic [7:0] TRAIL_HIGH_MIN = 8'h9F;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    // one job handed from the front to the back
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       wdata;
        logic              is_error;
        logic              is_end;
        logic [1:0]        advance;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    function automatic logic signed [CODE_W-1:0] rebuild_code(
        input logic [7:0] lead,
        input logic [7:0] nxt
    );
        logic signed [CODE_W-1:0] c;
        c = $signed({2'b00, lead, 9'b0}) - REBUILD_BASE;
        if (lead >= HIGH_LEAD_MIN) begin
            c = c - HIGH_LEAD_ADJ;
        end
        c = c + $signed({11'b0, nxt});
        if (nxt <= TRAIL_LOW_MAX) begin
            c = c - TRAIL_LOW_ADJ;
        end else if (nxt >= TRAIL_HIGH_MIN) begin
            c = c + TRAIL_HIGH_ADJ;
        end else begin
            c = c - TRAIL_MID_ADJ;
        end
        return c;
    endfunction

    function automatic logic [1:0] lead_advance(input logic [7:0] lead);
        logic [1:0] adv;
        if (lead inside {[8'h81:8'h9F], [8'hE0:8'hFC]}) begin
            adv = 2'd2;
        end else begin
            adv = 2'd1;
        end
        return adv;
    endfunction

endpackage

// ----- hdl/sjis_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sjis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sjis_queue.sv -----
// small register fifo between the front and back parts
// no dependencies
module sjis_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_data[r_rptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ----- hdl/sjis_front.sv -----
// front part: takes input requests, holds the range slots, matches converts against them
// and pushes one job per request into the queue; uses sjis_pkg
module sjis_front #(
    parameter int MAX_RANGES  = sjis_pkg::MAX_RANGES_DEF,
    parameter int TABLE_DEPTH = sjis_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [sjis_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [sjis_pkg::IN_USER_W-1:0] i_s_tuser,
    input  logic [4:0]                     i_range_count,
    output logic                           o_push,
    output sjis_pkg::t_job                 o_job,
    input  logic                           i_q_full
);

    localparam int RW = $clog2(MAX_RANGES);
    localparam int CW = sjis_pkg::CODE_W;

    logic        r_fv, n_fv;
    logic [1:0]  r_action;
    logic [7:0]  r_lead;
    logic [7:0]  r_next;
    logic [13:0] r_idx;
    logic [15:0] r_first;
    logic [15:0] r_last;
    logic [15:0] r_base;
    logic [15:0] r_word;

    logic [15:0] r_start  [MAX_RANGES];
    logic [15:0] r_end    [MAX_RANGES];
    logic [15:0] r_offset [MAX_RANGES];

    logic                 accept;
    logic                 range_wr;
    logic [RW-1:0]        range_slot;
    logic signed [CW-1:0] lead_code;
    logic signed [CW-1:0] full_code;
    logic [MAX_RANGES-1:0] hit;
    logic [RW-1:0]        sel;
    logic                 sel_low;
    logic signed [CW-1:0] sel_code;
    logic signed [CW-1:0] diff;
    logic [CW-1:0]        tidx;
    logic                 any_hit;
    logic                 in_table;

    assign o_push     = r_fv && !i_q_full;
    assign o_s_tready = !r_fv || o_push;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_fv = r_fv;
        if (accept) begin
            n_fv = 1'b1;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_s_tuser;
            r_lead   <= i_s_tdata[sjis_pkg::LEAD_LSB +: 8];
            r_next   <= i_s_tdata[sjis_pkg::NEXT_LSB +: 8];
            r_idx    <= i_s_tdata[sjis_pkg::IDX_LSB +: 14];
            r_first  <= i_s_tdata[sjis_pkg::FIRST_LSB +: 16];
            r_last   <= i_s_tdata[sjis_pkg::LAST_LSB +: 16];
            r_base   <= i_s_tdata[sjis_pkg::BASE_LSB +: 16];
            r_word   <= i_s_tdata[sjis_pkg::WORD_LSB +: 16];
        end
    end

    // range slot writes take effect as the request leaves, so later converts see them
    assign range_wr   = o_push && (r_action == sjis_pkg::ACT_RANGE)
                        && (r_idx < 14'(MAX_RANGES));
    assign range_slot = r_idx[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_RANGES; j++) begin
                r_start[j]  <= '0;
                r_end[j]    <= '0;
                r_offset[j] <= '0;
            end
        end else if (range_wr) begin
            r_start[range_slot]  <= r_first;
            r_end[range_slot]    <= r_last;
            r_offset[range_slot] <= r_base;
        end
    end

    assign lead_code = $signed({11'b0, r_lead});
    assign full_code = sjis_pkg::rebuild_code(r_lead, r_next);

    // slots 0 and 1 see the lead byte alone, later slots the rebuilt code
    always_comb begin
        logic signed [CW-1:0] c;
        for (int j = 0; j < MAX_RANGES; j++) begin
            c = (j < 2) ? lead_code : full_code;
            hit[j] = (7'(j) < {2'b0, i_range_count})
                     && (c >= $signed({3'b0, r_start[j]}))
                     && (c <= $signed({3'b0, r_end[j]}));
        end
    end

    always_comb begin
        sel     = '0;
        sel_low = 1'b1;
        for (int j = MAX_RANGES - 1; j >= 0; j--) begin
            if (hit[j]) begin
                sel     = RW'(j);
                sel_low = (j < 2);
            end
        end
    end

    assign any_hit  = |hit;
    assign sel_code = sel_low ? lead_code : full_code;
    assign diff     = sel_code - $signed({3'b0, r_start[sel]});
    assign tidx     = {3'b0, r_offset[sel]} + $unsigned(diff);
    assign in_table = tidx < CW'(TABLE_DEPTH);

    always_comb begin
        o_job          = '0;
        o_job.op       = sjis_pkg::OP_NONE;
        case (r_action)
            sjis_pkg::ACT_CONVERT: begin
                if (r_lead == 8'h00) begin
                    o_job.is_end = 1'b1;
                end else begin
                    o_job.advance = sjis_pkg::lead_advance(r_lead);
                    if (any_hit && in_table) begin
                        o_job.op   = sjis_pkg::OP_READ;
                        o_job.addr = tidx[sjis_pkg::ADDR_W-1:0];
                    end else begin
                        o_job.is_error = 1'b1;
                    end
                end
            end
            sjis_pkg::ACT_TABLE: begin
                if (17'(r_idx) < 17'(TABLE_DEPTH)) begin
                    o_job.op    = sjis_pkg::OP_WRITE;
                    o_job.addr  = sjis_pkg::ADDR_W'(r_idx);
                    o_job.wdata = r_word;
                end
            end
            default: begin
                o_job.op = sjis_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ----- hdl/sjis_back.sv -----
// back part: pops jobs, performs the code table access and drives the result register
// uses sjis_pkg and sjis_ram
module sjis_back #(
    parameter int TABLE_DEPTH = sjis_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  sjis_pkg::t_job                  i_job,
    output logic                            o_pop,
    input  logic [15:0]                     i_error_code,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sjis_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [sjis_pkg::OUT_USER_W-1:0] o_m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic        r_bv, n_bv;
    logic        r_b_read;
    logic        r_b_error;
    logic        r_b_end;
    logic [1:0]  r_b_adv;

    logic        r_ov, n_ov;
    logic [15:0] r_o_code;
    logic [1:0]  r_o_adv;
    logic        r_o_error;
    logic        r_o_end;

    logic        out_load;
    logic [15:0] rdata;
    logic [15:0] code;

    assign out_load = r_bv && (!r_ov || i_m_tready);
    assign o_pop    = !i_q_empty && (!r_bv || out_load);

    sjis_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (o_pop && (i_job.op == sjis_pkg::OP_WRITE)),
        .i_waddr (i_job.addr[AW-1:0]),
        .i_wdata (i_job.wdata),
        .i_re    (o_pop && (i_job.op == sjis_pkg::OP_READ)),
        .i_raddr (i_job.addr[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_bv = r_bv;
        if (o_pop) begin
            n_bv = 1'b1;
        end else if (out_load) begin
            n_bv = 1'b0;
        end
        n_ov = r_ov;
        if (out_load) begin
            n_ov = 1'b1;
        end else if (i_m_tready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_bv <= n_bv;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_read  <= (i_job.op == sjis_pkg::OP_READ);
            r_b_error <= i_job.is_error;
            r_b_end   <= i_job.is_end;
            r_b_adv   <= i_job.advance;
        end
    end

    // ram data holds until the next read, so a stalled job still sees its word
    always_comb begin
        if (r_b_read) begin
            code = rdata;
        end else if (r_b_error) begin
            code = i_error_code;
        end else begin
            code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_code  <= code;
            r_o_adv   <= r_b_adv;
            r_o_error <= r_b_error;
            r_o_end   <= r_b_end;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {6'b0, r_o_adv, r_o_code};
    assign o_m_tuser  = {r_o_end, r_o_error};

endmodule

// ----- hdl/sjis_to_ucs2_range_table.sv -----
// top level of the shift-jis to ucs-2 range table converter: config registers,
// front part, job queue and back part; uses sjis_pkg, sjis_front, sjis_queue, sjis_back
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------------------
//   s        | in        | i_s_tvalid/o_s_tready  | tdata 96b, tuser = action
//   m        | out       | o_m_tvalid/i_m_tready  | tdata 24b, tuser = {is_end, is_error}
//   apb      | in        | psel/penable/pready    | paddr 3b, 32b data, 2 registers
//
// one request per cycle is sustained in both parts unless the queue is full or the output
// is held; the table ram does at most one read or write per request. a result passes
// through the front register, the queue, the back register and the output register. the
// front and back stall on their own: the queue holds up to four jobs. reset is synchronous
// and clears all range slots and the config registers; the code table is not cleared.
module sjis_to_ucs2_range_table #(
    parameter int MAX_RANGES  = sjis_pkg::MAX_RANGES_DEF,
    parameter int TABLE_DEPTH = sjis_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // lead_byte[7:0], next_byte[15:8], entry_index[29:16], range_first[45:30],
    // range_last[61:46], range_base[77:62], table_word[93:78], zero pad
    input  logic [sjis_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [sjis_pkg::IN_USER_W-1:0]  i_s_tuser,   // action[1:0]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // char_code[15:0], advance[17:16], zero pad
    output logic [sjis_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [sjis_pkg::OUT_USER_W-1:0] o_m_tuser,   // is_error[0], is_end[1]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [4:0]  r_range_count;
    logic [15:0] r_error_code;
    logic        cfg_wr;

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    sjis_pkg::t_job push_job;
    sjis_pkg::t_job pop_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count <= '0;
            r_error_code  <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                sjis_pkg::REG_RANGE_COUNT: r_range_count <= pwdata[4:0];
                sjis_pkg::REG_ERROR_CODE:  r_error_code  <= pwdata[15:0];
                default:                   r_error_code  <= r_error_code;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sjis_pkg::REG_RANGE_COUNT: prdata = {27'b0, r_range_count};
            sjis_pkg::REG_ERROR_CODE:  prdata = {16'b0, r_error_code};
            default:                   prdata = '0;
        endcase
    end

    sjis_front #(
        .MAX_RANGES  (MAX_RANGES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_range_count (r_range_count),
        .o_push        (push),
        .o_job         (push_job),
        .i_q_full      (q_full)
    );

    sjis_queue #(
        .WIDTH (sjis_pkg::JOB_W),
        .DEPTH (sjis_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (q_empty)
    );

    sjis_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (pop_job),
        .o_pop        (pop),
        .i_error_code (r_error_code),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

// ----- bench/sjis_checker.sv -----
// result checker for the shift-jis to ucs-2 range table converter, plus a small helper package
// keeps its own range slots, code table and registers; depends on sjis_pkg
package sjis_tb_pkg;

    // two-byte code rebuilt from lead and trail byte, negative for low lead bytes
    function automatic int sjis_pair_code(input logic [7:0] lead, input logic [7:0] nxt);
        int c;
        c = int'(lead) * 'h200 - 'hE100;
        if (lead >= 8'hE0) begin
            c = c - 'h8000;
        end
        c = c + int'(nxt);
        if (nxt <= 8'h7E) begin
            c = c - 'h1F;
        end else if (nxt >= 8'h9F) begin
            c = c + 'h82;
        end else begin
            c = c - 'h20;
        end
        return c;
    endfunction

endpackage

module sjis_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // lead_byte, next_byte, entry_index, range_first, range_last, range_base, table_word
    input  logic [sjis_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [sjis_pkg::IN_USER_W-1:0]  i_s_tuser,   // action
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // char_code, advance, zero pad
    input  logic [sjis_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [sjis_pkg::OUT_USER_W-1:0] i_m_tuser,   // is_error, is_end
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    input  logic [31:0]                     prdata,
    input  logic                            pready,
    output int                              o_results_due,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = sjis_pkg::MAX_RANGES_DEF;
    localparam int CODE_DEPTH = sjis_pkg::TABLE_DEPTH_DEF;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CODE_AW    = $clog2(CODE_DEPTH);

    typedef struct packed {
        logic [15:0] char_code;
        logic [1:0]  advance;
        logic        is_error;
        logic        is_end;
    } t_ucs2_result;

    logic [4:0]   range_cnt;
    logic [15:0]  err_code;
    logic [15:0]  slot_first [NUM_SLOTS];
    logic [15:0]  slot_last  [NUM_SLOTS];
    logic [15:0]  slot_base  [NUM_SLOTS];
    logic [15:0]  code_words [CODE_DEPTH];
    t_ucs2_result pending_results [$];
    int           due_count  = 0;
    int           fail_count = 0;

    assign o_results_due = due_count;
    assign o_fail_count  = fail_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic t_ucs2_result translate_char(input logic [7:0] lead,
                                                    input logic [7:0] nxt);
        t_ucs2_result r;
        int           used;
        int           code;
        int           tidx;
        int           lo;
        int           hi;
        int           j;
        bit           hit;
        r = '0;
        if (lead == 8'h00) begin
            r.is_end = 1'b1;
            return r;
        end
        used = (int'(range_cnt) > NUM_SLOTS) ? NUM_SLOTS : int'(range_cnt);
        code = int'(lead);
        hit  = 1'b0;
        tidx = 0;
        // slots 0 and 1 see the single byte, later ones the rebuilt pair
        for (j = 0; j < used && !hit; j++) begin
            lo = int'(slot_first[j]);
            hi = int'(slot_last[j]);
            if (code >= lo && code <= hi) begin
                tidx = int'(slot_base[j]) + code - lo;
                hit  = 1'b1;
            end else if (j == 1) begin
                code = sjis_tb_pkg::sjis_pair_code(lead, nxt);
            end
        end
        if (hit && tidx < CODE_DEPTH) begin
            r.char_code = code_words[CODE_AW'(tidx)];
        end else begin
            r.char_code = err_code;
            r.is_error  = 1'b1;
        end
        if ((lead >= 8'h81 && lead <= 8'h9F) || (lead >= 8'hE0 && lead <= 8'hFC)) begin
            r.advance = 2'd2;
        end else begin
            r.advance = 2'd1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_ucs2_result got;
        t_ucs2_result want;
        logic [13:0]  idx;
        logic [31:0]  reg_val;
        if (!i_rst_n) begin
            pending_results.delete();
            range_cnt = '0;
            err_code  = '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                slot_first[k] = '0;
                slot_last[k]  = '0;
                slot_base[k]  = '0;
            end
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.char_code = i_m_tdata[15:0];
                got.advance   = i_m_tdata[17:16];
                got.is_error  = i_m_tuser[0];
                got.is_end    = i_m_tuser[1];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", {12'd0, got}, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.char_code !== want.char_code)
                        report_mismatch("char_code", 32'(got.char_code),
                                        32'(want.char_code));
                    if (got.advance !== want.advance)
                        report_mismatch("advance", 32'(got.advance), 32'(want.advance));
                    if (got.is_error !== want.is_error)
                        report_mismatch("is_error", 32'(got.is_error), 32'(want.is_error));
                    if (got.is_end !== want.is_end)
                        report_mismatch("is_end", 32'(got.is_end), 32'(want.is_end));
                end
            end

            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == sjis_pkg::REG_RANGE_COUNT) begin
                        range_cnt = pwdata[4:0];
                    end else begin
                        err_code = pwdata[15:0];
                    end
                end else begin
                    reg_val = (paddr[2] == sjis_pkg::REG_RANGE_COUNT)
                              ? {27'd0, range_cnt} : {16'd0, err_code};
                    if (prdata !== reg_val)
                        report_mismatch("register read", prdata, reg_val);
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                idx = i_s_tdata[sjis_pkg::IDX_LSB +: 14];
                case (i_s_tuser)
                    sjis_pkg::ACT_CONVERT: begin
                        pending_results.push_back(
                            translate_char(i_s_tdata[sjis_pkg::LEAD_LSB +: 8],
                                           i_s_tdata[sjis_pkg::NEXT_LSB +: 8]));
                    end
                    sjis_pkg::ACT_RANGE: begin
                        if (int'(idx) < NUM_SLOTS) begin
                            slot_first[idx[SLOT_W-1:0]] = i_s_tdata[sjis_pkg::FIRST_LSB +: 16];
                            slot_last[idx[SLOT_W-1:0]]  = i_s_tdata[sjis_pkg::LAST_LSB +: 16];
                            slot_base[idx[SLOT_W-1:0]]  = i_s_tdata[sjis_pkg::BASE_LSB +: 16];
                        end
                        pending_results.push_back('0);
                    end
                    sjis_pkg::ACT_TABLE: begin
                        if (int'(idx) < CODE_DEPTH) begin
                            code_words[idx[CODE_AW-1:0]] = i_s_tdata[sjis_pkg::WORD_LSB +: 16];
                        end
                        pending_results.push_back('0);
                    end
                    default: begin
                        pending_results.push_back('0);
                    end
                endcase
            end
        end
        due_count = pending_results.size();
    end

endmodule

// ----- bench/testbench.sv -----
// top of the converter testbench: clock, reset, stream and register stimulus, verdict
// drives sjis_to_ucs2_range_table and watches it through sjis_checker; uses sjis_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SLOT_W       = $clog2(sjis_pkg::MAX_RANGES_DEF);
    // hits only ever land in two fully written windows of the code table
    localparam int WINDOW       = 32;
    localparam int HIGH_BASE    = sjis_pkg::TABLE_DEPTH_DEF - WINDOW;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 50;
    localparam int LONG_HOLD_AT = 170;
    localparam int LONG_HOLD    = 100;
    localparam int SETTLE       = 8;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic [sjis_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [sjis_pkg::IN_USER_W-1:0]  s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [sjis_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [sjis_pkg::OUT_USER_W-1:0] m_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [2:0]                      paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    int                              results_due;
    int                              fail_count;
    bit                              idle_on = 1'b1;
    logic [7:0]                      anchor_lead [sjis_pkg::MAX_RANGES_DEF];
    logic [7:0]                      anchor_next [sjis_pkg::MAX_RANGES_DEF];

    always #6 clk = ~clk;

    sjis_to_ucs2_range_table u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    sjis_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_results_due (results_due),
        .o_fail_count  (fail_count)
    );

    function automatic logic [sjis_pkg::IN_DATA_W-1:0] noise_word();
        return {2'b00, $urandom(), $urandom(), 30'($urandom())};
    endfunction

    task automatic send_request(input logic [1:0] act,
                                input logic [sjis_pkg::IN_DATA_W-1:0] data);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tuser  <= act;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_convert(input logic [7:0] lead, input logic [7:0] nxt);
        logic [sjis_pkg::IN_DATA_W-1:0] data;
        data = noise_word();
        data[sjis_pkg::LEAD_LSB +: 8] = lead;
        data[sjis_pkg::NEXT_LSB +: 8] = nxt;
        send_request(sjis_pkg::ACT_CONVERT, data);
    endtask

    task automatic send_range(input logic [13:0] slot, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [15:0] base);
        logic [sjis_pkg::IN_DATA_W-1:0] data;
        data = noise_word();
        data[sjis_pkg::IDX_LSB +: 14]   = slot;
        data[sjis_pkg::FIRST_LSB +: 16] = lo;
        data[sjis_pkg::LAST_LSB +: 16]  = hi;
        data[sjis_pkg::BASE_LSB +: 16]  = base;
        send_request(sjis_pkg::ACT_RANGE, data);
    endtask

    task automatic send_word(input logic [13:0] addr, input logic [15:0] word);
        logic [sjis_pkg::IN_DATA_W-1:0] data;
        data = noise_word();
        data[sjis_pkg::IDX_LSB +: 14]  = addr;
        data[sjis_pkg::WORD_LSB +: 16] = word;
        send_request(sjis_pkg::ACT_TABLE, data);
    endtask

    // new range around a remembered character, so converts can aim at it
    task automatic load_range(input int slot);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] base;
        logic [7:0]  lead;
        logic [7:0]  nxt;
        int          span;
        span = $urandom_range(0, WINDOW - 1);
        nxt  = 8'($urandom_range(0, 255));
        if (slot < 2) begin
            lo   = 16'($urandom_range(1, 255 - span));
            lead = 8'(lo + 16'($urandom_range(0, span)));
        end else begin
            lead = ($urandom_range(0, 1) == 1) ? 8'($urandom_range('h81, 'h9F))
                                               : 8'($urandom_range('hE0, 'hFF));
            lo   = 16'(sjis_tb_pkg::sjis_pair_code(lead, nxt) - int'($urandom_range(0, span)));
        end
        hi   = lo + 16'(span);
        base = 16'($urandom_range(0, WINDOW - 1 - span));
        anchor_lead[SLOT_W'(slot)] = lead;
        anchor_next[SLOT_W'(slot)] = nxt;
        case ($urandom_range(0, 7))
            0: begin
                // empty range, kept clear of wrapping below zero
                if (lo > 16'd7) begin
                    hi = lo - 16'd1 - 16'($urandom_range(0, 7));
                end
            end
            1, 2: base = 16'($urandom_range(HIGH_BASE, 65535));
            3: begin
                // any bounds at all, every index lands past the table
                base = 16'($urandom_range(sjis_pkg::TABLE_DEPTH_DEF, 65535));
                lo   = 16'($urandom_range(0, 65535));
                hi   = 16'($urandom_range(0, 65535));
            end
            default: ;
        endcase
        send_range(14'(slot), lo, hi, base);
    endtask

    task automatic random_request();
        int pick;
        int slot;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, sjis_pkg::MAX_RANGES_DEF - 1);
        if (pick < 60) begin
            if (slot < 2) begin
                send_convert(anchor_lead[SLOT_W'(slot)], 8'($urandom_range(0, 255)));
            end else begin
                send_convert(anchor_lead[SLOT_W'(slot)],
                             8'(anchor_next[SLOT_W'(slot)] + $urandom_range(0, 4) - 2));
            end
        end else if (pick < 66) begin
            send_convert(8'h00, 8'($urandom_range(0, 255)));
        end else if (pick < 78) begin
            send_convert(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            load_range(slot);
        end else if (pick < 91) begin
            send_range(14'($urandom_range(sjis_pkg::MAX_RANGES_DEF, 16383)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
        end else if (pick < 97) begin
            send_word(14'($urandom_range(0, 16383)), 16'($urandom_range(0, 65535)));
        end else begin
            send_request(ACT_UNUSED, noise_word());
        end
    endtask

    // register write followed by a read-back, only while the block is idle
    task automatic set_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin : receiver
        int seen;
        bit held;
        seen = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) seen++;
            if (!held && seen >= LONG_HOLD_AT) begin
                // long back-pressure so the queue fills and the input stalls
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : limit
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int cnt;
        int ecode;
        rst_n    <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= sjis_pkg::ACT_CONVERT;
        s_tvalid <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_reg(sjis_pkg::REG_ERROR_CODE, 32'hFFFF_FFFF);
        set_reg(sjis_pkg::REG_RANGE_COUNT, 32'd31);     // above the slot count, acts as all slots

        for (int i = 0; i < WINDOW; i++) begin
            send_word(14'(i), 16'($urandom_range(0, 65535)));
            send_word(14'(HIGH_BASE + i), 16'($urandom_range(0, 65535)));
        end
        send_range(14'd0, 16'h0020, 16'h003F, 16'd0);
        send_range(14'd1, 16'h00A1, 16'h00BF, 16'd0);
        anchor_lead[0] = 8'h20;
        anchor_lead[1] = 8'hA1;
        // slot 2 swallows every non-negative rebuilt code, with an index that lands past the table
        send_range(14'd2, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_convert(8'h81, 8'h40);
        send_convert(8'hFC, 8'hFC);
        for (int s = 2; s < sjis_pkg::MAX_RANGES_DEF; s++) begin
            load_range(s);
        end

        send_convert(8'h00, 8'h00);
        send_convert(8'h00, 8'hFF);
        send_convert(8'h20, 8'hFF);
        send_convert(8'h3F, 8'h00);
        send_convert(8'h1F, 8'h7E);           // misses both byte slots, negative code
        send_convert(8'hA1, 8'h7F);
        send_convert(8'hBF, 8'h9E);
        send_convert(8'h80, 8'h7F);
        send_convert(8'h81, 8'h9F);
        send_convert(8'h9F, 8'hFC);
        send_convert(8'hA0, 8'h40);
        send_convert(8'hDF, 8'h80);
        send_convert(8'hE0, 8'h7E);
        send_convert(8'hFC, 8'hFF);
        send_convert(8'hFD, 8'h9F);
        send_convert(8'hFF, 8'hFF);
        send_convert(anchor_lead[2], anchor_next[2]);
        send_convert(anchor_lead[15], anchor_next[15]);
        send_request(ACT_UNUSED, {2'b00, {94{1'b1}}});
        send_range(14'(sjis_pkg::MAX_RANGES_DEF), 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_range(14'h3FFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_word(14'h3FFF, 16'hFFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            ecode = $urandom_range(0, 65535);
            case (ph)
                0: cnt = 16;
                1: begin cnt = 0; ecode = 0; end
                2: begin cnt = 1; ecode = 16'hFFFF; end
                3: cnt = 2;
                4: cnt = $urandom_range(17, 31);
                5: cnt = $urandom_range(3, 15);
                default: cnt = 16;
            endcase
            if (ph == PHASES - 1) idle_on = 1'b0;
            set_reg(sjis_pkg::REG_RANGE_COUNT, {27'($urandom()), 5'(cnt)});
            set_reg(sjis_pkg::REG_ERROR_CODE, {16'($urandom()), 16'(ecode)});
            repeat (PHASE_ITEMS) random_request();
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sjis_pkg.sv
hdl/sjis_ram.sv
hdl/sjis_queue.sv
hdl/sjis_front.sv
hdl/sjis_back.sv
hdl/sjis_to_ucs2_range_table.sv
bench/sjis_checker.sv
bench/testbench.sv
